>>> rtl/core/tasd_pkg.sv
// ----------------------------------------------------------------------------
// tasd_pkg
// Shared types and constants for the two-axis settle detector.
// ----------------------------------------------------------------------------
package tasd_pkg;

	localparam int ERROR_WINDOW = 8;
	localparam int FULL_WINDOW  = 8;
	localparam int X_OFFSET     = 45;

	localparam int RUN_W = 4;
	localparam logic [RUN_W-1:0] RUN_MAX = '1;

	// signed error of one axis and its sample-to-sample change
	localparam int ERR_W   = 10;
	localparam int DELTA_W = 11;

	typedef logic signed [ERR_W-1:0]   err_t;
	typedef logic signed [DELTA_W-1:0] delta_t;

	typedef enum logic [2:0] {
		REG_TARGET_X      = 3'd0,
		REG_TARGET_Y      = 3'd1,
		REG_X_ERROR_LIMIT = 3'd2,
		REG_Y_ERROR_LIMIT = 3'd3,
		REG_X_RATE_LIMIT  = 3'd4,
		REG_Y_RATE_LIMIT  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [8:0] target_x;
		logic signed [8:0] target_y;
		logic [8:0]        x_error_limit;
		logic [8:0]        y_error_limit;
		logic [9:0]        x_rate_limit;
		logic [9:0]        y_rate_limit;
	} cfg_t;

	typedef struct packed {
		err_t error_x;
		err_t error_y;
		logic err_ok;
		logic full_ok;
	} eval_t;

	function automatic logic [DELTA_W-2:0] mag_delta(input delta_t v);
		delta_t a;
		a = (v < 0) ? -v : v;
		return a[DELTA_W-2:0];
	endfunction

endpackage

>>> rtl/core/tasd_eval.sv
// ----------------------------------------------------------------------------
// tasd_eval
// Forms both axis errors and their changes, checks them against the limits.
// ----------------------------------------------------------------------------
module tasd_eval import tasd_pkg::*; (
	input  logic [7:0] x_reading,
	input  logic [7:0] y_reading,
	input  cfg_t       cfg,
	input  err_t       prior_err_x,
	input  err_t       prior_err_y,
	output eval_t      result
);

	delta_t ex_wide;
	delta_t ey_wide;
	delta_t dx;
	delta_t dy;
	logic   x_in;
	logic   y_in;
	logic   x_still;
	logic   y_still;

	// errors stay within -300..511 so the 11-bit sums never wrap
	assign ex_wide = delta_t'({3'b000, x_reading}) - delta_t'(X_OFFSET)
		- delta_t'(cfg.target_x);
	assign ey_wide = delta_t'({3'b000, y_reading}) - delta_t'(cfg.target_y);

	assign dx = ex_wide - delta_t'(prior_err_x);
	assign dy = ey_wide - delta_t'(prior_err_y);

	assign x_in    = mag_delta(ex_wide) <= {1'b0, cfg.x_error_limit};
	assign y_in    = mag_delta(ey_wide) <= {1'b0, cfg.y_error_limit};
	assign x_still = mag_delta(dx) <= cfg.x_rate_limit;
	assign y_still = mag_delta(dy) <= cfg.y_rate_limit;

	always_comb begin
		result.error_x = ex_wide[ERR_W-1:0];
		result.error_y = ey_wide[ERR_W-1:0];
		result.err_ok  = x_in && y_in;
		result.full_ok = x_in && y_in && x_still && y_still;
	end

endmodule

>>> rtl/core/two_axis_settle_detector.sv
// ----------------------------------------------------------------------------
// two_axis_settle_detector
// In-position detection with dwell on two axes and a one-shot trigger.
// ----------------------------------------------------------------------------
// channel   handshake              payload
// cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
// in        in_valid/in_ready      x_reading, y_reading, rearm
// out       out_valid/out_ready    error_settled, fully_settled, trigger_pulse
//
// one item per cycle while the result is not stalled
// item goes input register -> compare logic -> result register
// the run counters, previous errors and trigger latch update as the result loads
// a stalled result holds both stages; the input register still fills if empty
// reset clears all control state and the configuration registers
// ----------------------------------------------------------------------------
module two_axis_settle_detector import tasd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [9:0] cfg_data,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] x_reading,
	input  logic [7:0] y_reading,
	input  logic       rearm,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       error_settled,
	output logic       fully_settled,
	output logic       trigger_pulse
);

	cfg_t             cfg_q;
	logic             valid_s1;
	logic [7:0]       x_s1;
	logic [7:0]       y_s1;
	logic             rearm_s1;
	logic             valid_s2;
	logic             err_settled_s2;
	logic             full_settled_s2;
	logic             pulse_s2;
	err_t             prev_x_q;
	err_t             prev_y_q;
	logic [RUN_W-1:0] err_run_q;
	logic [RUN_W-1:0] full_run_q;
	logic             latch_q;
	eval_t            ev;
	logic             advance;
	logic             take;
	logic [RUN_W-1:0] err_run_next;
	logic [RUN_W-1:0] full_run_next;
	logic             latch_clr;
	logic             err_settled;
	logic             pulse;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_TARGET_X:      cfg_q.target_x      <= cfg_data[8:0];
				REG_TARGET_Y:      cfg_q.target_y      <= cfg_data[8:0];
				REG_X_ERROR_LIMIT: cfg_q.x_error_limit <= cfg_data[8:0];
				REG_Y_ERROR_LIMIT: cfg_q.y_error_limit <= cfg_data[8:0];
				REG_X_RATE_LIMIT:  cfg_q.x_rate_limit  <= cfg_data;
				REG_Y_RATE_LIMIT:  cfg_q.y_rate_limit  <= cfg_data;
				default: ;
			endcase
		end
	end

	// result register free or being emptied
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign take     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_s1     <= x_reading;
			y_s1     <= y_reading;
			rearm_s1 <= rearm;
		end
	end

	tasd_eval u_eval (
		.x_reading   (x_s1),
		.y_reading   (y_s1),
		.cfg         (cfg_q),
		.prior_err_x (prev_x_q),
		.prior_err_y (prev_y_q),
		.result      (ev)
	);

	assign err_run_next  = !ev.err_ok ? '0 :
		(err_run_q == RUN_MAX) ? RUN_MAX : err_run_q + 1'b1;
	assign full_run_next = !ev.full_ok ? '0 :
		(full_run_q == RUN_MAX) ? RUN_MAX : full_run_q + 1'b1;

	assign latch_clr   = rearm_s1 ? 1'b0 : latch_q;
	assign err_settled = err_run_next >= RUN_W'(ERROR_WINDOW);
	assign pulse       = err_settled && !latch_clr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			err_run_q  <= '0;
			full_run_q <= '0;
			latch_q    <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (take) begin
				prev_x_q   <= ev.error_x;
				prev_y_q   <= ev.error_y;
				err_run_q  <= err_run_next;
				full_run_q <= full_run_next;
				latch_q    <= latch_clr || pulse;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			err_settled_s2  <= err_settled;
			full_settled_s2 <= full_run_next >= RUN_W'(FULL_WINDOW);
			pulse_s2        <= pulse;
		end
	end

	assign out_valid     = valid_s2;
	assign error_settled = err_settled_s2;
	assign fully_settled = full_settled_s2;
	assign trigger_pulse = pulse_s2;

endmodule
